[hdl/sbh_pkg.sv]
// ----------------------------------------------------------------------------
// sbh_pkg: shared constants and types for the string bucket hash
// Widths, register indexes, reset values and the divider status record.
// ----------------------------------------------------------------------------
package sbh_pkg;

    // field widths
    localparam int ACC_W       = 32;
    localparam int CHAR_W      = 8;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;
    localparam int DIV_CNT_W   = $clog2(ACC_W);

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_BUCKET_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_CASE_FOLD    = 1'b1;

    // register reset values
    localparam logic [ACC_W-1:0] BUCKET_COUNT_RESET = 32'd1024;
    localparam logic             CASE_FOLD_RESET    = 1'b0;

    // hash constants
    localparam int HASH_SHIFT_LEFT  = 3;
    localparam int HASH_SHIFT_RIGHT = 28;
    localparam logic [CHAR_W-1:0] UPPER_FIRST = 8'h41;
    localparam logic [CHAR_W-1:0] UPPER_LAST  = 8'h5A;
    localparam logic [CHAR_W-1:0] LOWER_FIRST = 8'h61;

    // divider status seen by the top level
    typedef struct packed {
        logic busy;   // no new dividend can be taken
        logic done;   // remainder is valid and waiting
    } div_status_t;

endpackage

[hdl/sbh_if.sv]
// ----------------------------------------------------------------------------
// sbh_if: item channels of the string bucket hash
// Valid/ready channels for the incoming characters and the outgoing buckets.
// ----------------------------------------------------------------------------
interface sbh_char_if;
    logic                                valid;
    logic                                ready;
    logic signed [sbh_pkg::CHAR_W-1:0]   char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface sbh_bucket_if;
    logic                          valid;
    logic                          ready;
    logic [sbh_pkg::ACC_W-1:0]     bucket;

    modport source (output valid, output bucket, input ready);
    modport sink   (input valid, input bucket, output ready);
endinterface

[hdl/sbh_acc.sv]
// ----------------------------------------------------------------------------
// sbh_acc: hash accumulator
// Folds one character per cycle, while en is high, into the 32-bit shift-add hash.
// ----------------------------------------------------------------------------
module sbh_acc (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              clr,
    input  logic                              case_fold,
    input  logic signed [sbh_pkg::CHAR_W-1:0] char_code,
    output logic [sbh_pkg::ACC_W-1:0]         acc
);
    import sbh_pkg::*;

    logic [CHAR_W-1:0] char_fold;
    logic [ACC_W-1:0]  char_ext;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;

    // optional upper to lower case mapping
    always_comb
    begin
        char_fold = char_code;
        if (case_fold && (char_code inside {[UPPER_FIRST:UPPER_LAST]}))
        begin
            char_fold = char_code - UPPER_FIRST + LOWER_FIRST;
        end
    end

    // sign extension
    assign char_ext = {{(ACC_W-CHAR_W){char_fold[CHAR_W-1]}}, char_fold};

    // acc*9 + (acc>>28) + char, wrapping; clr clears to zero
    always_comb
    begin
        acc_next = acc_reg;
        if (clr)
        begin
            acc_next = '0;
        end
        else if (en)
        begin
            acc_next = acc_reg + (acc_reg << HASH_SHIFT_LEFT)
                     + (acc_reg >> HASH_SHIFT_RIGHT) + char_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

[hdl/sbh_div.sv]
// ----------------------------------------------------------------------------
// sbh_div: bit-serial remainder unit
// Restoring division, one dividend bit per cycle; keeps only the remainder.
// ----------------------------------------------------------------------------
module sbh_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      take,
    input  logic [sbh_pkg::ACC_W-1:0] dividend,
    input  logic [sbh_pkg::ACC_W-1:0] divisor,
    output logic [sbh_pkg::ACC_W-1:0] rem,
    output sbh_pkg::div_status_t      status
);
    import sbh_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;
    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(ACC_W - 1);

    logic [1:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [ACC_W-1:0]     rem_reg, rem_next;
    logic [ACC_W-1:0]     dvd_reg, dvd_next;
    logic [ACC_W:0]       shifted;
    logic [ACC_W:0]       diff;

    // one restoring step
    assign shifted = {rem_reg, dvd_reg[ACC_W-1]};
    assign diff    = shifted - {1'b0, divisor};

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    rem_next   = '0;
                    dvd_next   = dividend;
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                rem_next = (shifted >= {1'b0, divisor}) ? diff[ACC_W-1:0]
                                                        : shifted[ACC_W-1:0];
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
    end

    assign rem         = rem_reg;
    assign status.busy = (state_reg != ST_IDLE);
    assign status.done = (state_reg == ST_DONE);

endmodule

[hdl/string_bucket_hash_top.sv]
// ----------------------------------------------------------------------------
// string_bucket_hash_top: bucket number of a name streamed by character
// Shift-add string hash reduced modulo a configurable bucket count.
// ----------------------------------------------------------------------------
// Usage:
//   chars carries one signed character per item; a zero character ends
//   the name. buckets carries one item per name: the hash modulo
//   bucket_count. Registers (cfg_we/cfg_index/cfg_data): index 0 is
//   bucket_count, index 1 is case_fold; write them only while idle.
// Timing:
//   a non-zero character is taken every cycle while chars.ready is high
//   and updates the registered hash. The terminator starts the bit-serial
//   remainder unit, which works through the dividend one bit at a time;
//   chars.ready is low while the unit runs and while the remainder waits
//   in it to move to the output register. The bucket is loaded into the
//   output register from the unit's done state once that register is free.
// Stalls:
//   while a bucket waits in the output register, characters of the next
//   name are still taken; a finished remainder waits in the unit until the
//   output register is free, and chars.ready stays low meanwhile.
// Reset:
//   clears the hash, the handshake state and sets bucket_count to 1024 and
//   case_fold to 0.
// ----------------------------------------------------------------------------
module string_bucket_hash_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sbh_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [sbh_pkg::CFG_DATA_W-1:0]      cfg_data,
    sbh_char_if.sink                            chars,
    sbh_bucket_if.source                        buckets
);
    import sbh_pkg::*;

    logic [ACC_W-1:0] bucket_count_reg;
    logic             case_fold_reg;
    logic             in_take;
    logic             name_end;
    logic [ACC_W-1:0] acc;
    logic [ACC_W-1:0] rem;
    div_status_t      div_status;
    logic             div_take;
    logic             out_valid_reg, out_valid_next;
    logic [ACC_W-1:0] bucket_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_count_reg <= BUCKET_COUNT_RESET;
            case_fold_reg    <= CASE_FOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BUCKET_COUNT: bucket_count_reg <= cfg_data[ACC_W-1:0];
                REG_CASE_FOLD:    case_fold_reg    <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // input handshake
    assign chars.ready = !div_status.busy;
    assign in_take     = chars.valid && chars.ready;
    assign name_end    = (chars.char_code == '0);

    sbh_acc u_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (in_take && !name_end),
        .clr       (in_take && name_end),
        .case_fold (case_fold_reg),
        .char_code (chars.char_code),
        .acc       (acc)
    );

    sbh_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_take && name_end),
        .take     (div_take),
        .dividend (acc),
        .divisor  (bucket_count_reg),
        .rem      (rem),
        .status   (div_status)
    );

    // output register
    assign div_take = div_status.done && (!out_valid_reg || buckets.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (div_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (buckets.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_take)
        begin
            bucket_reg <= rem;
        end
    end

    assign buckets.valid  = out_valid_reg;
    assign buckets.bucket = bucket_reg;

endmodule
